FILE: hw/rtl/statevector_controlled_gate_engine_assert.svh
// Assertion macros for the statevector controlled-gate engine.
// Expects clk and rst in the including scope; empty under SYNTHESIS.
`ifndef STATEVECTOR_CONTROLLED_GATE_ENGINE_ASSERT_SVH
`define STATEVECTOR_CONTROLLED_GATE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define SVCE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svce assertion failed");
`define SVCE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svce assertion failed");
`else
`define SVCE_ASSERT_IMP(lbl, ante, cons)
`define SVCE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/svce_pkg.sv
// Shared types, codes and arithmetic helpers of the statevector gate engine.
// No dependencies.
package svce_pkg;

  localparam int AMP_W   = 32;
  localparam int ADDR_W  = 10;
  localparam int QUBIT_W = 4;
  localparam int MASK_W  = 10;
  localparam int QCNT_W  = 5;
  localparam int ACC_W   = 35;
  localparam int DEF_MAX_QUBITS = 10;
  localparam logic [3:0] AQ_RESET = 4'd10;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_GATE  = 2'd2;

  localparam logic [2:0] G_CCX   = 3'd0;
  localparam logic [2:0] G_CCZ   = 3'd1;
  localparam logic [2:0] G_CSWAP = 3'd2;
  localparam logic [2:0] G_RCCX  = 3'd3;
  localparam logic [2:0] G_MCX   = 3'd4;
  localparam logic [2:0] G_MCP   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_DISTINCT = 2'd2;

  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_SWAP  = 3'd1;
  localparam logic [2:0] ACT_NEG   = 3'd2;
  localparam logic [2:0] ACT_RCCX  = 3'd3;
  localparam logic [2:0] ACT_PHASE = 3'd4;

  localparam logic [1:0] RS_ADDR = 2'd0;
  localparam logic [1:0] RS_IDX  = 2'd1;
  localparam logic [1:0] RS_PAIR = 2'd2;

  localparam logic [2:0] MUL_LAST = 3'd4;

  typedef struct packed {
    logic       load;
    logic       mem_wr_item;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap0;
    logic       cap1;
    logic       clr_idx;
    logic       inc_idx;
    logic       mul_en;
    logic [2:0] mul_k;
    logic       wr_en;
    logic       wr_slot;
    logic       result_load;
  } svce_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       go_sweep;
    logic [2:0] act;
    logic       last;
  } svce_stat_t;

  function automatic logic signed [AMP_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-AMP_W+1){1'b0}}, {(AMP_W-1){1'b1}}};
    lo = {{(ACC_W-AMP_W+1){1'b1}}, {(AMP_W-1){1'b0}}};
    if (v > hi) sat_acc = {1'b0, {(AMP_W-1){1'b1}}};
    else if (v < lo) sat_acc = {1'b1, {(AMP_W-1){1'b0}}};
    else sat_acc = v[AMP_W-1:0];
  endfunction

  function automatic logic [AMP_W-1:0] neg_sat(input logic [AMP_W-1:0] v);
    if (v == {1'b1, {(AMP_W-1){1'b0}}}) neg_sat = {1'b0, {(AMP_W-1){1'b1}}};
    else neg_sat = -v;
  endfunction

endpackage

FILE: hw/rtl/svce_req_if.sv
// Request channel of the statevector gate engine: valid, ready and one word.
// Depends on svce_pkg.
interface svce_req_if import svce_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 op;
  logic [ADDR_W-1:0]          addr;
  logic signed [AMP_W-1:0]    write_real;
  logic signed [AMP_W-1:0]    write_imag;
  logic [2:0]                 gate_kind;
  logic [QUBIT_W-1:0]         qubit_a;
  logic [QUBIT_W-1:0]         qubit_b;
  logic [QUBIT_W-1:0]         qubit_c;
  logic [MASK_W-1:0]          control_mask;
  logic signed [AMP_W-1:0]    phase_cos;
  logic signed [AMP_W-1:0]    phase_sin;

  modport source(output valid, op, addr, write_real, write_imag, gate_kind, qubit_a,
                 qubit_b, qubit_c, control_mask, phase_cos, phase_sin, input ready);
  modport sink(input valid, op, addr, write_real, write_imag, gate_kind, qubit_a,
               qubit_b, qubit_c, control_mask, phase_cos, phase_sin, output ready);
endinterface

FILE: hw/rtl/svce_rsp_if.sv
// Response channel of the statevector gate engine: valid, ready and one word.
// Depends on svce_pkg.
interface svce_rsp_if import svce_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [AMP_W-1:0] read_real;
  logic signed [AMP_W-1:0] read_imag;
  logic [1:0]              status;

  modport source(output valid, read_real, read_imag, status, input ready);
  modport sink(input valid, read_real, read_imag, status, output ready);
endinterface

FILE: hw/rtl/svce_ctrl.sv
// Sequencer of the statevector gate engine: accepts words, steps the store sweep.
// Depends on svce_pkg.
module svce_ctrl import svce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  input  svce_stat_t stat,
  output svce_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_RDJ    = 4'd3;
  localparam logic [3:0] S_CAPJ   = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_WRI    = 4'd6;
  localparam logic [3:0] S_WRJ    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state, state_next;
  logic [2:0] k, k_next;
  logic       outv, outv_next;
  logic       pair;

  assign pair      = (stat.act == ACT_SWAP) || (stat.act == ACT_RCCX);
  assign req_ready = (state == S_IDLE);
  assign rsp_valid = outv;

  always_comb begin
    cmd        = '0;
    state_next = state;
    k_next     = k;
    outv_next  = outv && !rsp_ready;
    cmd.mul_k  = k;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        case (stat.op)
          OP_WRITE: cmd.mem_wr_item = 1'b1;
          OP_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RS_ADDR;
          end
          OP_GATE: begin
            if (stat.go_sweep) begin
              cmd.clr_idx = 1'b1;
              state_next  = S_SCAN;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RS_IDX;
        if (stat.act != ACT_NONE) state_next = S_RDJ;
        else if (stat.last) state_next = S_DONE;
        else cmd.inc_idx = 1'b1;
      end
      S_RDJ: begin
        cmd.cap0   = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RS_PAIR;
        k_next     = '0;
        if (pair) state_next = S_CAPJ;
        else if (stat.act == ACT_PHASE) state_next = S_MUL;
        else state_next = S_WRI;
      end
      S_CAPJ: begin
        cmd.cap1   = 1'b1;
        state_next = S_WRI;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        k_next     = k + 3'd1;
        if (k == MUL_LAST) state_next = S_WRI;
      end
      S_WRI: begin
        cmd.wr_en = 1'b1;
        if (pair) state_next = S_WRJ;
        else if (stat.last) state_next = S_DONE;
        else begin
          cmd.inc_idx = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_WRJ: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_slot = 1'b1;
        if (stat.last) state_next = S_DONE;
        else begin
          cmd.inc_idx = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_DONE: begin
        if (!outv || rsp_ready) begin
          cmd.result_load = 1'b1;
          outv_next       = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      outv  <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      outv  <= outv_next;
    end
  end

endmodule

FILE: hw/rtl/svce_dp.sv
// Datapath of the statevector gate engine: amplitude store, operand checks,
// sweep index, phase multiplier and result word. Depends on svce_pkg.
module svce_dp import svce_pkg::*; #(
  parameter int MAX_QUBITS = DEF_MAX_QUBITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [3:0]              cfg_data,
  input  logic [1:0]              op,
  input  logic [ADDR_W-1:0]       addr,
  input  logic [AMP_W-1:0]        write_real,
  input  logic [AMP_W-1:0]        write_imag,
  input  logic [2:0]              gate_kind,
  input  logic [QUBIT_W-1:0]      qubit_a,
  input  logic [QUBIT_W-1:0]      qubit_b,
  input  logic [QUBIT_W-1:0]      qubit_c,
  input  logic [MASK_W-1:0]       control_mask,
  input  logic signed [AMP_W-1:0] phase_cos,
  input  logic signed [AMP_W-1:0] phase_sin,
  input  svce_cmd_t               cmd,
  output svce_stat_t              stat,
  output logic [AMP_W-1:0]        read_real,
  output logic [AMP_W-1:0]        read_imag,
  output logic [1:0]              status
);

  localparam int AW    = MAX_QUBITS;
  localparam int DEPTH = 2**AW;

  logic [AMP_W-1:0] mem_re [DEPTH];
  logic [AMP_W-1:0] mem_im [DEPTH];

  logic [3:0]              aq;
  logic [1:0]              op_q;
  logic [ADDR_W-1:0]       addr_q;
  logic [AMP_W-1:0]        wre_q, wim_q;
  logic [2:0]              kind_q;
  logic [QUBIT_W-1:0]      qa_q, qb_q, qc_q;
  logic [MASK_W-1:0]       mask_q;
  logic signed [AMP_W-1:0] cos_q, sin_q;

  logic [AW-1:0]           idx;
  logic [AMP_W-1:0]        rd_re, rd_im, h0_re, h0_im, h1_re, h1_im;
  logic signed [2*AMP_W-1:0] prod;
  logic signed [ACC_W-1:0] acc_re, acc_im;
  logic [AMP_W-1:0]        out_re, out_im;
  logic [1:0]              out_st;

  logic [QCNT_W-1:0]       n;
  logic [AW:0]             dimv, dim_m1;
  logic [AW-1:0]           ab, bb, cb, mk, jx, raddr, waddr, addr_aw;
  logic [AW+ADDR_W-1:0]    atmp;
  logic [AW+MASK_W-1:0]    mtmp;
  logic [MASK_W-1:0]       msh;
  logic [1:0]              st_code;
  logic                    addr_bad, mask_bad, qa_bad, qb_bad, qc_bad, dup;
  logic                    a1, b1, c1, mfull, we;
  logic [AMP_W-1:0]        wd_re, wd_im;
  logic signed [AMP_W-1:0] mul_a, mul_b;
  logic signed [2*AMP_W-1:0] prnd;
  logic signed [ACC_W-1:0] rnd;

  // Qubit count clamped to the legal range.
  always_comb begin
    if (aq == 4'd0) n = QCNT_W'(1);
    else if ({1'b0, aq} > QCNT_W'(MAX_QUBITS)) n = QCNT_W'(MAX_QUBITS);
    else n = {1'b0, aq};
  end

  assign dimv    = (AW+1)'(1) << n;
  assign dim_m1  = dimv - (AW+1)'(1);
  assign atmp    = {AW'(0), addr_q};
  assign addr_aw = atmp[AW-1:0];
  assign mtmp    = {AW'(0), mask_q};
  assign mk      = mtmp[AW-1:0];
  assign ab      = AW'(1) << qa_q;
  assign bb      = AW'(1) << qb_q;
  assign cb      = AW'(1) << qc_q;
  assign msh     = mask_q >> qc_q;

  assign addr_bad = (addr_q >> n) != '0;
  assign mask_bad = (mask_q >> n) != '0;
  assign qa_bad   = {1'b0, qa_q} >= n;
  assign qb_bad   = {1'b0, qb_q} >= n;
  assign qc_bad   = {1'b0, qc_q} >= n;
  assign dup      = (qa_q == qb_q) || (qa_q == qc_q) || (qb_q == qc_q);

  always_comb begin
    st_code = ST_OK;
    case (op_q) inside
      OP_WRITE, OP_READ: if (addr_bad) st_code = ST_RANGE;
      OP_GATE: begin
        case (kind_q) inside
          G_CCX, G_CCZ, G_CSWAP, G_RCCX: begin
            if (qa_bad || qb_bad || qc_bad) st_code = ST_RANGE;
            else if (dup) st_code = ST_DISTINCT;
          end
          G_MCX: begin
            if (mask_bad || qc_bad) st_code = ST_RANGE;
            else if (msh[0]) st_code = ST_DISTINCT;
          end
          G_MCP: if (mask_bad) st_code = ST_RANGE;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Per-entry action of the current gate.
  assign a1    = |(idx & ab);
  assign b1    = |(idx & bb);
  assign c1    = |(idx & cb);
  assign mfull = (idx & mk) == mk;
  assign jx    = (kind_q == G_CSWAP) ? ((idx & ~bb) | cb) : (idx | cb);

  always_comb begin
    stat.act = ACT_NONE;
    case (kind_q) inside
      G_CCX, G_CSWAP: if (a1 && b1 && !c1) stat.act = ACT_SWAP;
      G_CCZ: if (a1 && b1 && c1) stat.act = ACT_NEG;
      G_RCCX: begin
        if (a1 && !b1 && c1) stat.act = ACT_NEG;
        else if (a1 && b1 && !c1) stat.act = ACT_RCCX;
      end
      G_MCX: if (!c1 && mfull) stat.act = ACT_SWAP;
      G_MCP: if (mfull) stat.act = ACT_PHASE;
      default: ;
    endcase
  end

  assign stat.op       = op_q;
  assign stat.go_sweep = (op_q == OP_GATE) && (kind_q <= G_MCP) && (st_code == ST_OK);
  assign stat.last     = idx == dim_m1[AW-1:0];

  // Store ports.
  always_comb begin
    case (cmd.rd_sel)
      RS_ADDR: raddr = addr_aw;
      RS_IDX:  raddr = idx;
      default: raddr = jx;
    endcase
  end

  always_comb begin
    waddr = addr_aw;
    wd_re = wre_q;
    wd_im = wim_q;
    if (cmd.wr_en) begin
      waddr = cmd.wr_slot ? jx : idx;
      case (stat.act)
        ACT_SWAP: begin
          wd_re = cmd.wr_slot ? h0_re : h1_re;
          wd_im = cmd.wr_slot ? h0_im : h1_im;
        end
        ACT_NEG: begin
          wd_re = neg_sat(h0_re);
          wd_im = neg_sat(h0_im);
        end
        ACT_RCCX: begin
          wd_re = cmd.wr_slot ? neg_sat(h0_im) : h1_im;
          wd_im = cmd.wr_slot ? h0_re : neg_sat(h1_re);
        end
        default: begin
          wd_re = sat_acc(acc_re);
          wd_im = sat_acc(acc_im);
        end
      endcase
    end
  end

  assign we = cmd.wr_en || (cmd.mem_wr_item && !addr_bad);

  always_ff @(posedge clk) begin
    if (we) begin
      mem_re[waddr] <= wd_re;
      mem_im[waddr] <= wd_im;
    end
    if (cmd.rd_en) begin
      rd_re <= mem_re[raddr];
      rd_im <= mem_im[raddr];
    end
  end

  // Phase multiply: one product a cycle, rounded and summed the next cycle.
  always_comb begin
    case (cmd.mul_k)
      3'd0: begin mul_a = h0_re; mul_b = cos_q; end
      3'd1: begin mul_a = h0_im; mul_b = sin_q; end
      3'd2: begin mul_a = h0_re; mul_b = sin_q; end
      default: begin mul_a = h0_im; mul_b = cos_q; end
    endcase
  end

  assign prnd = prod + (2*AMP_W)'(64'sd536870912);
  assign rnd  = ACC_W'($signed(prnd[2*AMP_W-1:30]));

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
      case (cmd.mul_k)
        3'd1: acc_re <= rnd;
        3'd2: acc_re <= acc_re - rnd;
        3'd3: acc_im <= rnd;
        3'd4: acc_im <= acc_im + rnd;
        default: ;
      endcase
    end
    if (cmd.cap0) begin
      h0_re <= rd_re;
      h0_im <= rd_im;
    end
    if (cmd.cap1) begin
      h1_re <= rd_re;
      h1_im <= rd_im;
    end
  end

  // Item capture, sweep index and result word.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op;
      addr_q <= addr;
      wre_q  <= write_real;
      wim_q  <= write_imag;
      kind_q <= gate_kind;
      qa_q   <= qubit_a;
      qb_q   <= qubit_b;
      qc_q   <= qubit_c;
      mask_q <= control_mask;
      cos_q  <= phase_cos;
      sin_q  <= phase_sin;
    end
    if (cmd.clr_idx) idx <= '0;
    else if (cmd.inc_idx) idx <= idx + AW'(1);
    if (cmd.result_load) begin
      out_st <= st_code;
      if (op_q == OP_READ && st_code == ST_OK) begin
        out_re <= rd_re;
        out_im <= rd_im;
      end else begin
        out_re <= '0;
        out_im <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) aq <= AQ_RESET;
    else if (cfg_we) aq <= cfg_data;
  end

  assign read_real = out_re;
  assign read_imag = out_im;
  assign status    = out_st;

endmodule

FILE: hw/rtl/statevector_controlled_gate_engine.sv
// Top level of the statevector controlled-gate engine: sequencer plus datapath.
// Depends on svce_pkg, svce_req_if, svce_rsp_if, svce_ctrl, svce_dp.
//
//   channel | dir | word
//   req     | in  | op, addr, write amplitude, gate kind, qubits, mask, cos/sin
//   rsp     | out | read amplitude, status
//   cfg     | in  | active qubit count (write enable + data)
//
// Write or read: decode, then the result register loads once rsp is free.
// Gate: decode, then a sweep of 2^n store entries, each scanned; a negated entry
// is then captured and written back, a swapped or RCCX pair also captures its
// partner and writes both slots, a phased entry runs the phase multiply first.
// One read and one write port (one read, one write a cycle) set the sweep rate.
// Reset clears control state only; the store is undefined until written.
// A result waiting on rsp does not block the next request from being accepted.
module statevector_controlled_gate_engine import svce_pkg::*; #(
  parameter int MAX_QUBITS = DEF_MAX_QUBITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data,
  svce_req_if.sink   req,
  svce_rsp_if.source rsp
);

`include "statevector_controlled_gate_engine_assert.svh"

  svce_cmd_t  cmd;
  svce_stat_t stat;

  // Sequencer: handshakes and per-entry step order.
  svce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: store, checks, arithmetic and result word.
  svce_dp #(
    .MAX_QUBITS (MAX_QUBITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .op           (req.op),
    .addr         (req.addr),
    .write_real   (req.write_real),
    .write_imag   (req.write_imag),
    .gate_kind    (req.gate_kind),
    .qubit_a      (req.qubit_a),
    .qubit_b      (req.qubit_b),
    .qubit_c      (req.qubit_c),
    .control_mask (req.control_mask),
    .phase_cos    (req.phase_cos),
    .phase_sin    (req.phase_sin),
    .cmd          (cmd),
    .stat         (stat),
    .read_real    (rsp.read_real),
    .read_imag    (rsp.read_imag),
    .status       (rsp.status)
  );

  // Hold off new words once one is taken.
  `SVCE_ASSERT_NXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
  // Store writes only while busy.
  `SVCE_ASSERT_IMP(a_wr_busy, cmd.wr_en || cmd.mem_wr_item, !req.ready)
  // Status codes stay within the defined set.
  `SVCE_ASSERT_IMP(a_status_code, rsp.valid, rsp.status != 2'd3)
  // Error results carry zero parts.
  `SVCE_ASSERT_IMP(a_err_zero, rsp.valid && rsp.status != ST_OK,
                   rsp.read_real == '0 && rsp.read_imag == '0)

endmodule

FILE: test/svce_test_if.sv
// Testbench-side view of the engine's request and response channels.
// Depends on svce_pkg; the channels themselves are the RTL interfaces svce_req_if and svce_rsp_if.
package svce_test_pkg;
  import svce_pkg::*;

  typedef struct packed {
    logic [1:0]              op;
    logic [ADDR_W-1:0]       addr;
    logic signed [AMP_W-1:0] write_real;
    logic signed [AMP_W-1:0] write_imag;
    logic [2:0]              gate_kind;
    logic [QUBIT_W-1:0]      qubit_a;
    logic [QUBIT_W-1:0]      qubit_b;
    logic [QUBIT_W-1:0]      qubit_c;
    logic [MASK_W-1:0]       control_mask;
    logic signed [AMP_W-1:0] phase_cos;
    logic signed [AMP_W-1:0] phase_sin;
  } gate_word_t;

  typedef struct packed {
    logic signed [AMP_W-1:0] read_real;
    logic signed [AMP_W-1:0] read_imag;
    logic [1:0]              status;
  } amp_result_t;
endpackage

FILE: test/statevector_controlled_gate_engine_test.sv
// Self-checking testbench of the statevector controlled-gate engine.
// Depends on svce_pkg, svce_test_pkg, the request/response interfaces and the RTL top.
module statevector_controlled_gate_engine_test;
  import svce_pkg::*;
  import svce_test_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 9000;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [3:0] cfg_data;

  svce_req_if req ();
  svce_rsp_if rsp ();

  statevector_controlled_gate_engine dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data), .req(req), .rsp(rsp)
  );

  // Shadow of the engine: amplitude store, written flags and qubit count.
  logic signed [31:0] shadow_re [1024];
  logic signed [31:0] shadow_im [1024];
  bit                 shadow_set [1024];
  logic [3:0]         qubit_reg;
  logic [3:0]         qubit_settings [9];
  amp_result_t        pending_results [$];
  int                 mismatches;
  int                 idle_cycles;
  bit                 sending;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int qubits_used();
    if (qubit_reg == 0) return 1;
    if (qubit_reg > 10) return 10;
    return qubit_reg;
  endfunction

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] negate_sat(input logic signed [31:0] v);
    return sat32(-longint'(v));
  endfunction

  // Round half up to Q1.30; the arithmetic shift floors.
  function automatic longint round_q30(input longint a, input longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic void swap_entries(input int i, input int j);
    logic signed [31:0] t;
    t = shadow_re[i]; shadow_re[i] = shadow_re[j]; shadow_re[j] = t;
    t = shadow_im[i]; shadow_im[i] = shadow_im[j]; shadow_im[j] = t;
  endfunction

  // Apply a gate to the shadow store and return its status.
  function automatic logic [1:0] apply_gate(input gate_word_t w);
    int n, dim, ab, bb, cb, j;
    logic signed [31:0] r0, m0, r1, m1;
    longint r, m;
    n = qubits_used();
    dim = 1 << n;
    if (w.gate_kind > G_MCP) return ST_OK;
    if (w.gate_kind <= G_RCCX) begin
      if (w.qubit_a >= n || w.qubit_b >= n || w.qubit_c >= n) return ST_RANGE;
      if (w.qubit_a == w.qubit_b || w.qubit_a == w.qubit_c || w.qubit_b == w.qubit_c)
        return ST_DISTINCT;
      ab = 1 << w.qubit_a; bb = 1 << w.qubit_b; cb = 1 << w.qubit_c;
      for (int i = 0; i < dim; i++) begin
        bit a1, b1, c1;
        a1 = (i & ab) != 0; b1 = (i & bb) != 0; c1 = (i & cb) != 0;
        case (w.gate_kind)
          G_CCX: if (a1 && b1 && !c1) swap_entries(i, i | cb);
          G_CCZ: if (a1 && b1 && c1) begin
            shadow_re[i] = negate_sat(shadow_re[i]);
            shadow_im[i] = negate_sat(shadow_im[i]);
          end
          G_CSWAP: if (a1 && b1 && !c1) swap_entries(i, (i & ~bb) | cb);
          default: begin
            if (a1 && !b1 && c1) begin
              shadow_re[i] = negate_sat(shadow_re[i]);
              shadow_im[i] = negate_sat(shadow_im[i]);
            end
            if (a1 && b1 && !c1) begin
              j = i | cb;
              r0 = shadow_re[i]; m0 = shadow_im[i]; r1 = shadow_re[j]; m1 = shadow_im[j];
              shadow_re[i] = m1;
              shadow_im[i] = negate_sat(r1);
              shadow_re[j] = negate_sat(m0);
              shadow_im[j] = r0;
            end
          end
        endcase
      end
      return ST_OK;
    end
    if ((int'(w.control_mask) >> n) != 0) return ST_RANGE;
    if (w.gate_kind == G_MCX) begin
      if (w.qubit_c >= n) return ST_RANGE;
      cb = 1 << w.qubit_c;
      if ((w.control_mask & cb) != 0) return ST_DISTINCT;
      for (int i = 0; i < dim; i++)
        if ((i & cb) == 0 && (i & w.control_mask) == w.control_mask) swap_entries(i, i | cb);
      return ST_OK;
    end
    for (int i = 0; i < dim; i++) begin
      if ((i & w.control_mask) == w.control_mask) begin
        r = shadow_re[i]; m = shadow_im[i];
        shadow_re[i] = sat32(round_q30(r, w.phase_cos) - round_q30(m, w.phase_sin));
        shadow_im[i] = sat32(round_q30(r, w.phase_sin) + round_q30(m, w.phase_cos));
      end
    end
    return ST_OK;
  endfunction

  // Work out the result of one accepted word and update the shadow.
  function automatic amp_result_t predict_amplitude(input gate_word_t w);
    amp_result_t res;
    int dim;
    res = '0;
    dim = 1 << qubits_used();
    case (w.op)
      OP_WRITE: if (w.addr >= dim) res.status = ST_RANGE;
        else begin
          shadow_re[w.addr] = w.write_real;
          shadow_im[w.addr] = w.write_imag;
          shadow_set[w.addr] = 1'b1;
        end
      OP_READ: if (w.addr >= dim) res.status = ST_RANGE;
        else begin
          res.read_real = shadow_re[w.addr];
          res.read_imag = shadow_im[w.addr];
        end
      OP_GATE: res.status = apply_gate(w);
      default: ;
    endcase
    return res;
  endfunction

  // Drive one word, holding it through random stalls until accepted.
  task automatic send_word(input gate_word_t w);
    req.valid        <= 1'b1;
    req.op           <= w.op;
    req.addr         <= w.addr;
    req.write_real   <= w.write_real;
    req.write_imag   <= w.write_imag;
    req.gate_kind    <= w.gate_kind;
    req.qubit_a      <= w.qubit_a;
    req.qubit_b      <= w.qubit_b;
    req.qubit_c      <= w.qubit_c;
    req.control_mask <= w.control_mask;
    req.phase_cos    <= w.phase_cos;
    req.phase_sin    <= w.phase_sin;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(predict_amplitude(w));
  endtask

  // Drop valid for a gap of random length; a zero gap keeps back-to-back words.
  task automatic idle_gap(input int cycles);
    if (cycles == 0) return;
    req.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold until every expected word has come back, then let the engine settle.
  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_qubit_count(input logic [3:0] value);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    qubit_reg = value;
    @(posedge clk);
  endtask

  function automatic gate_word_t amp_word(input logic [1:0] op, input int addr,
                                          input logic [31:0] re, input logic [31:0] im);
    gate_word_t w;
    w = '0;
    w.op = op; w.addr = addr; w.write_real = re; w.write_imag = im;
    return w;
  endfunction

  function automatic gate_word_t gate_word(input logic [2:0] kind, input int qa, input int qb,
                                           input int qc, input int mask,
                                           input logic [31:0] c, input logic [31:0] s);
    gate_word_t w;
    w = '0;
    w.op = OP_GATE; w.gate_kind = kind; w.qubit_a = qa; w.qubit_b = qb; w.qubit_c = qc;
    w.control_mask = mask; w.phase_cos = c; w.phase_sin = s;
    return w;
  endfunction

  // Random word; gates are mostly well formed, reads only touch written entries.
  function automatic gate_word_t random_word();
    gate_word_t w;
    int n, pick, dim;
    n = qubits_used();
    dim = 1 << n;
    w = '0;
    w.addr         = $urandom;
    w.write_real   = $urandom;
    w.write_imag   = $urandom;
    w.gate_kind    = $urandom;
    w.control_mask = $urandom;
    w.phase_cos    = $urandom_range(2147483647) - 1073741824;
    w.phase_sin    = $urandom_range(2147483647) - 1073741824;
    if ($urandom_range(15) == 0) begin
      w.phase_cos = ($urandom_range(1)) ? 32'sd1073741824 : -32'sd1073741824;
      w.phase_sin = ($urandom_range(1)) ? 32'sd1073741824 : -32'sd1073741824;
    end
    if ($urandom_range(7) == 0) begin
      w.write_real = $urandom_range(1) ? 32'sh80000000 : 32'sh7fffffff;
      w.write_imag = $urandom_range(1) ? 32'sh80000000 : 32'sh7fffffff;
    end
    pick = $urandom_range(99);
    if (pick < 35) begin
      w.op = OP_WRITE;
      if ($urandom_range(9) != 0) w.addr = $urandom_range(dim - 1);
    end else if (pick < 55) begin
      w.op = OP_READ;
      w.addr = $urandom_range(dim - 1);
      // Now and then an address past the store; an unwritten entry turns into a write.
      if (dim < 1024 && $urandom_range(9) == 0) w.addr = $urandom_range(1023, dim);
      else if (!shadow_set[w.addr]) w.op = OP_WRITE;
    end else if (pick < 95) begin
      w.op = OP_GATE;
      w.gate_kind = $urandom_range(5);
      w.qubit_a = $urandom_range(n - 1);
      if (n >= 2) w.qubit_b = (w.qubit_a + 1 + $urandom_range(n - 2)) % n;
      w.qubit_c = $urandom_range(n - 1);
      // Fewer than three qubits: repeats cannot be avoided and give an error status.
      if (n >= 3)
        while (w.qubit_c == w.qubit_a || w.qubit_c == w.qubit_b)
          w.qubit_c = $urandom_range(n - 1);
      w.control_mask = $urandom_range(dim - 1);
      if (w.gate_kind == G_MCX) w.control_mask &= ~(10'd1 << w.qubit_c);
      // Broken operands now and then: out of range or repeated qubits.
      case ($urandom_range(11))
        0: w.qubit_a = $urandom_range(15);
        1: w.qubit_c = w.qubit_b;
        2: w.control_mask = $urandom;
        3: w.control_mask |= 10'd1 << w.qubit_c;
        default: ;
      endcase
    end else begin
      w.op = $urandom_range(3);
      w.gate_kind = $urandom_range(7);
      w.qubit_a = $urandom; w.qubit_b = $urandom; w.qubit_c = $urandom;
      // Never read or gate over entries that were not written yet.
      if (w.op == OP_READ && w.addr < dim && !shadow_set[w.addr]) w.op = 2'd3;
      if (w.op == OP_GATE && w.gate_kind <= G_MCP) w.op = 2'd3;
    end
    return w;
  endfunction

  // Fill the whole active store so that every later read or gate is defined.
  task automatic fill_store();
    for (int a = 0; a < (1 << qubits_used()); a++) begin
      send_word(amp_word(OP_WRITE, a, $urandom, $urandom));
      idle_gap($urandom_range(3) == 0 ? $urandom_range(3) : 0);
    end
  endtask

  // Directed rows: word plus optional typed-in expectation.
  typedef struct {
    gate_word_t  word;
    bit          typed;
    amp_result_t expected;
  } stim_row_t;

  stim_row_t directed_rows [$];

  task automatic run_directed();
    amp_result_t predicted;
    foreach (directed_rows[k]) begin
      send_word(directed_rows[k].word);
      if (directed_rows[k].typed) begin
        predicted = pending_results[$];
        if (predicted != directed_rows[k].expected) begin
          $error("directed row %0d: typed %h, predicted %h", k,
                 directed_rows[k].expected, predicted);
          mismatches++;
        end
      end
      idle_gap($urandom_range(1));
    end
  endtask

  function automatic void add_row(input gate_word_t w, input bit typed, input amp_result_t e);
    stim_row_t r;
    r.word = w; r.typed = typed; r.expected = e;
    directed_rows.push_back(r);
  endfunction

  // Receiver: stalls in a pattern of its own, checks each word against the oldest expectation.
  initial begin
    amp_result_t got, want;
    int phase;
    rsp.ready <= 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        got.read_real = rsp.read_real;
        got.read_imag = rsp.read_imag;
        got.status    = rsp.status;
        if (pending_results.size() == 0) begin
          $error("unexpected result word %h", got);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.read_real !== want.read_real) begin
            $error("read_real expected %h actual %h", want.read_real, got.read_real);
            mismatches++;
          end
          if (got.read_imag !== want.read_imag) begin
            $error("read_imag expected %h actual %h", want.read_imag, got.read_imag);
            mismatches++;
          end
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            mismatches++;
          end
        end
      end
      // Long ready stretches, bursts of stalls, and a slow toggle stretch.
      phase = (phase + 1) % 200;
      if (phase < 80) rsp.ready <= 1'b1;
      else if (phase < 140) rsp.ready <= ($urandom_range(3) != 0);
      else rsp.ready <= phase[2];
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    amp_result_t ok_zero, rng, dst;
    gate_word_t w;
    bit big;
    int sent, burst, drain;
    ok_zero = '0;
    rng = '0; rng.status = ST_RANGE;
    dst = '0; dst.status = ST_DISTINCT;
    mismatches = 0;
    qubit_reg = AQ_RESET;
    qubit_settings = '{4'd3, 4'd1, 4'd5, 4'd0, 4'd10, 4'd4, 4'd15, 4'd2, 4'd6};
    for (int a = 0; a < 1024; a++) begin
      shadow_re[a] = '0; shadow_im[a] = '0; shadow_set[a] = 1'b0;
    end
    cfg_we <= 1'b0;
    cfg_data <= '0;
    req.valid <= 1'b0;
    req.op <= '0; req.addr <= '0; req.write_real <= '0; req.write_imag <= '0;
    req.gate_kind <= '0; req.qubit_a <= '0; req.qubit_b <= '0; req.qubit_c <= '0;
    req.control_mask <= '0; req.phase_cos <= '0; req.phase_sin <= '0;
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Small store first: 3 qubits, then directed rows over every gate and error.
    write_qubit_count(4'd3);
    fill_store();
    add_row(amp_word(OP_WRITE, 0, 32'sh7fffffff, 32'sh80000000), 1, ok_zero);
    add_row(amp_word(OP_READ, 0, '0, '0), 1,
            '{read_real: 32'sh7fffffff, read_imag: 32'sh80000000, status: ST_OK});
    add_row(amp_word(OP_WRITE, 7, 32'sh80000000, 32'sh80000000), 1, ok_zero);
    add_row(amp_word(OP_WRITE, 1023, 32'sh1, 32'sh1), 1, rng);
    add_row(amp_word(OP_READ, 8, '0, '0), 1, rng);
    add_row(gate_word(G_CCZ, 0, 1, 2, 0, 0, 0), 1, ok_zero);   // saturating negation
    add_row(amp_word(OP_READ, 7, '0, '0), 0, ok_zero);
    add_row(gate_word(G_CCX, 0, 1, 2, 0, 0, 0), 0, ok_zero);
    add_row(gate_word(G_CSWAP, 2, 0, 1, 0, 0, 0), 0, ok_zero);
    add_row(gate_word(G_RCCX, 1, 2, 0, 0, 0, 0), 0, ok_zero);
    add_row(gate_word(G_MCX, 0, 0, 2, 3'b011, 0, 0), 0, ok_zero);
    add_row(gate_word(G_MCX, 0, 0, 1, 0, 0, 0), 0, ok_zero);    // empty mask is plain X
    add_row(gate_word(G_MCP, 0, 0, 0, 0, 32'sd1073741824, 32'sd0), 0, ok_zero);
    add_row(gate_word(G_MCP, 0, 0, 0, 3'b101, -32'sd1073741824, 32'sd1073741824), 0, ok_zero);
    add_row(gate_word(G_CCX, 15, 1, 2, 0, 0, 0), 1, rng);
    add_row(gate_word(G_CCX, 1, 1, 2, 0, 0, 0), 1, dst);
    add_row(gate_word(G_MCX, 0, 0, 2, 10'h3ff, 0, 0), 1, rng);
    add_row(gate_word(G_MCX, 0, 0, 1, 3'b011, 0, 0), 1, dst);
    add_row(gate_word(G_MCP, 0, 0, 0, 10'h200, 0, 0), 1, rng);
    add_row(gate_word(3'd7, 15, 15, 15, 10'h3ff, 0, 0), 1, ok_zero);
    add_row(amp_word(2'd3, 1023, 32'shffffffff, 32'shffffffff), 1, ok_zero);
    for (int a = 0; a < 8; a++) add_row(amp_word(OP_READ, a, '0, '0), 0, ok_zero);
    run_directed();

    // Random phases over several qubit counts, the extremes and the clamped codes among them.
    sent = 0;
    for (int p = 0; p < 9; p++) begin
      write_qubit_count(qubit_settings[p]);
      // A full store is too long to load: plain reads and writes only there.
      big = qubits_used() >= 10;
      if (!big) fill_store();
      for (int k = 0; k < (big ? 15 : 55); k++) begin
        w = random_word();
        if (big && w.op == OP_GATE) w.op = OP_WRITE;
        send_word(w);
        sent++;
        burst = $urandom_range(7);
        if (k % 8 == burst) idle_gap($urandom_range(6));
      end
    end

    wait_drained();
    drain = 0;
    while (pending_results.size() != 0 && drain < DRAIN_CYCLES) begin
      @(posedge clk);
      drain++;
    end
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/svce_pkg.sv
hw/rtl/svce_req_if.sv
hw/rtl/svce_rsp_if.sv
hw/rtl/svce_ctrl.sv
hw/rtl/svce_dp.sv
hw/rtl/statevector_controlled_gate_engine.sv
test/svce_test_if.sv
test/statevector_controlled_gate_engine_test.sv
